### rtl/core/jdc_pkg.sv
// Constants, types and helper functions shared by the Julian day to calendar pipeline.
`default_nettype none

package jdc_pkg;

  // Day split: t / 86400000 is done as (t >> 10) / 84375 by a reciprocal product
  localparam int unsigned    DAY_SHIFT       = 10;
  localparam logic [48:0]    MS_HALF_DAY     = 49'd43200000;
  localparam logic [16:0]    DAY_DIV         = 17'd84375;

  // Calendar constants, all scaled to whole numbers
  localparam logic [21:0]    GREGORIAN_START = 22'd2299161;
  localparam logic [23:0]    ALPHA_OFS       = 24'd7468865;
  localparam logic [21:0]    B_OFS           = 22'd1524;
  localparam logic [25:0]    C_SCALE         = 26'd20;
  localparam logic [25:0]    C_OFS           = 26'd2442;
  localparam logic [24:0]    D_SCALE         = 25'd1461;
  localparam logic [22:0]    E_SCALE         = 23'd10000;
  localparam logic [14:0]    YEAR_OFS_LATE   = 15'd4716;
  localparam logic [14:0]    YEAR_OFS_EARLY  = 15'd4715;
  localparam logic [3:0]     MONTH_WRAP      = 4'd14;
  localparam logic [3:0]     FEBRUARY        = 4'd2;

  // Reciprocals: q = (n * ceil(2^k / d)) >> k, k = width(n) + ceil(log2 d)
  localparam int unsigned    DAY_K           = 56;
  localparam longint unsigned DAY_RECIP_L    = ((64'd1 << DAY_K) + 64'd84375 - 64'd1) / 64'd84375;
  localparam logic [39:0]    DAY_RECIP       = DAY_RECIP_L[39:0];

  localparam int unsigned    ALPHA_K         = 41;
  localparam longint unsigned ALPHA_RECIP_L  = ((64'd1 << ALPHA_K) + 64'd146097 - 64'd1) / 64'd146097;
  localparam logic [23:0]    ALPHA_RECIP     = ALPHA_RECIP_L[23:0];

  localparam int unsigned    C_K             = 39;
  localparam longint unsigned C_RECIP_L      = ((64'd1 << C_K) + 64'd7305 - 64'd1) / 64'd7305;
  localparam logic [26:0]    C_RECIP         = C_RECIP_L[26:0];

  localparam int unsigned    E_K             = 42;
  localparam longint unsigned E_RECIP_L      = ((64'd1 << E_K) + 64'd306001 - 64'd1) / 64'd306001;
  localparam logic [23:0]    E_RECIP         = E_RECIP_L[23:0];

  // Time of day: ms / 1000 as (ms >> 3) / 125, then / 60 twice as (x >> 2) / 15
  localparam int unsigned    MS_K            = 31;
  localparam longint unsigned MS_RECIP_L     = ((64'd1 << MS_K) + 64'd125 - 64'd1) / 64'd125;
  localparam logic [24:0]    MS_RECIP        = MS_RECIP_L[24:0];

  localparam int unsigned    SEC_K           = 19;
  localparam longint unsigned SEC_RECIP_L    = ((64'd1 << SEC_K) + 64'd15 - 64'd1) / 64'd15;
  localparam logic [15:0]    SEC_RECIP       = SEC_RECIP_L[15:0];

  localparam int unsigned    MIN_K           = 13;
  localparam longint unsigned MIN_RECIP_L    = ((64'd1 << MIN_K) + 64'd15 - 64'd1) / 64'd15;
  localparam logic [9:0]     MIN_RECIP       = MIN_RECIP_L[9:0];

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millisecond;
  } tod_t;

  // floor(30.6001 * e)
  function automatic logic [8:0] month_days(input logic [3:0] e);
    logic [8:0] r;
    unique case (e)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      default: r = 9'd459;
    endcase
    month_days = r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/jdc_day_split.sv
// Three-stage reciprocal divider: splits a millisecond count into day number and ms of day.
`default_nettype none

module jdc_day_split (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [48:0] t_i,
  output logic        valid_o,
  output logic [21:0] z_o,
  output logic [26:0] msd_o
);

  logic [2:0]  vld_q;

  // stage 1: partial products
  logic [38:0] num;
  logic [38:0] s1_hh_d;
  logic [38:0] s1_hl_d;
  logic [39:0] s1_lh_d;
  logic [39:0] s1_ll_d;
  logic [38:0] s1_hh_q;
  logic [38:0] s1_hl_q;
  logic [39:0] s1_lh_q;
  logic [39:0] s1_ll_q;
  logic [16:0] s1_nlo_q;
  logic [9:0]  s1_tlo_q;

  // stage 2: day number
  logic [78:0] s2_sum;
  logic [21:0] s2_z_q;
  logic [16:0] s2_nlo_q;
  logic [9:0]  s2_tlo_q;

  // stage 3: remainder
  logic [38:0] s3_prod;
  logic [16:0] s3_rem;
  logic [21:0] s3_z_q;
  logic [26:0] s3_msd_q;

  always_comb begin
    // split the 39-bit numerator into 19 and 20 bits and the 40-bit reciprocal into halves of 20 bits
    num     = t_i[48:jdc_pkg::DAY_SHIFT];
    s1_hh_d = 39'(num[38:20]) * 39'(jdc_pkg::DAY_RECIP[39:20]);
    s1_hl_d = 39'(num[38:20]) * 39'(jdc_pkg::DAY_RECIP[19:0]);
    s1_lh_d = 40'(num[19:0]) * 40'(jdc_pkg::DAY_RECIP[39:20]);
    s1_ll_d = 40'(num[19:0]) * 40'(jdc_pkg::DAY_RECIP[19:0]);

    s2_sum  = (79'(s1_hh_q) << 40) + (79'(s1_hl_q) << 20) + (79'(s1_lh_q) << 20)
              + 79'(s1_ll_q);

    // the remainder is below 2^17, so the low bits of the difference are enough
    s3_prod = 39'(s2_z_q) * 39'(jdc_pkg::DAY_DIV);
    s3_rem  = s2_nlo_q - s3_prod[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_hh_q  <= s1_hh_d;
      s1_hl_q  <= s1_hl_d;
      s1_lh_q  <= s1_lh_d;
      s1_ll_q  <= s1_ll_d;
      s1_nlo_q <= num[16:0];
      s1_tlo_q <= t_i[jdc_pkg::DAY_SHIFT-1:0];

      s2_z_q   <= s2_sum[jdc_pkg::DAY_K+21:jdc_pkg::DAY_K];
      s2_nlo_q <= s1_nlo_q;
      s2_tlo_q <= s1_tlo_q;

      s3_z_q   <= s2_z_q;
      s3_msd_q <= {s3_rem, s2_tlo_q};
    end
  end

  assign valid_o = vld_q[2];
  assign z_o     = s3_z_q;
  assign msd_o   = s3_msd_q;

endmodule

`default_nettype wire

### rtl/core/jdc_calendar.sv
// Pipeline from day number and ms of day to year, month, day and time of day.
`default_nettype none

module jdc_calendar (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [21:0]        z_i,
  input  logic [26:0]        msd_i,
  output logic               valid_o,
  output logic [13:0]        year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_o,
  output jdc_pkg::tod_t      tod_o
);

  localparam int unsigned NSTG = 9;

  logic [NSTG-1:0] vld_q;

  // date path
  logic [21:0] s1_z_q, s2_z_q;
  logic        s1_greg_q, s2_greg_q;
  logic [22:0] s1_anum_q;
  logic [46:0] s2_pa_q;
  logic [21:0] s3_b_q, s4_b_q, s5_b_q, s6_b_q;
  logic [25:0] s4_cnum_q;
  logic [52:0] s5_pc_q;
  logic [13:0] s6_c_q, s7_c_q, s8_c_q, s9_c_q;
  logic [8:0]  s7_bd_q, s8_bd_q, s9_bd_q;
  logic [22:0] s8_ne_q;
  logic [46:0] s9_pe_q;

  // time path
  logic [26:0] s1_msd_q;
  logic [48:0] s1_pms_q;
  logic [16:0] s2_sec_q, s3_sec_q;
  logic [9:0]  s2_ms_q, s3_ms_q, s4_ms_q, s5_ms_q;
  logic [30:0] s3_psec_q;
  logic [10:0] s4_min_q, s5_min_q;
  logic [5:0]  s4_second_q, s5_second_q;
  logic [18:0] s5_pmin_q;
  jdc_pkg::tod_t s6_tod_q, s7_tod_q, s8_tod_q, s9_tod_q;

  // next values
  logic        s1_greg_d;
  logic [23:0] s1_four_z;
  logic [22:0] s1_anum_d;
  logic [48:0] s1_pms_d;
  logic [16:0] s2_sec_d;
  logic [26:0] s2_msfull;
  logic [9:0]  s2_ms_d;
  logic [46:0] s2_pa_d;
  logic [5:0]  s3_alpha;
  logic [21:0] s3_a;
  logic [21:0] s3_b_d;
  logic [30:0] s3_psec_d;
  logic [25:0] s4_cnum_d;
  logic [10:0] s4_min_d;
  logic [16:0] s4_secfull;
  logic [5:0]  s4_second_d;
  logic [52:0] s5_pc_d;
  logic [18:0] s5_pmin_d;
  logic [13:0] s6_c_d;
  logic [4:0]  s6_hour;
  logic [10:0] s6_minfull;
  jdc_pkg::tod_t s6_tod_d;
  logic [24:0] s7_dprod;
  logic [22:0] s7_bdfull;
  logic [8:0]  s7_bd_d;
  logic [22:0] s8_ne_d;
  logic [46:0] s9_pe_d;

  always_comb begin
    // stage 1: Gregorian test, alpha numerator, ms of day reciprocal product
    s1_greg_d = (z_i >= jdc_pkg::GREGORIAN_START);
    s1_four_z = {z_i, 2'b00} - jdc_pkg::ALPHA_OFS;
    s1_anum_d = s1_greg_d ? s1_four_z[22:0] : '0;
    s1_pms_d  = 49'(msd_i[26:3]) * 49'(jdc_pkg::MS_RECIP);

    // stage 2
    s2_pa_d   = 47'(s1_anum_q) * 47'(jdc_pkg::ALPHA_RECIP);
    s2_sec_d  = s1_pms_q[47:jdc_pkg::MS_K];
    s2_msfull = s1_msd_q - 27'(s2_sec_d) * 27'd1000;
    s2_ms_d   = s2_msfull[9:0];

    // stage 3: A and B
    s3_alpha  = s2_pa_q[46:jdc_pkg::ALPHA_K];
    s3_a      = s2_greg_q ? (s2_z_q + 22'd1 + 22'(s3_alpha) - 22'(s3_alpha[5:2])) : s2_z_q;
    s3_b_d    = s3_a + jdc_pkg::B_OFS;
    s3_psec_d = 31'(s2_sec_q[16:2]) * 31'(jdc_pkg::SEC_RECIP);

    // stage 4
    s4_cnum_d   = 26'(s3_b_q) * jdc_pkg::C_SCALE - jdc_pkg::C_OFS;
    s4_min_d    = s3_psec_q[29:jdc_pkg::SEC_K];
    s4_secfull  = s3_sec_q - 17'(s4_min_d) * 17'd60;
    s4_second_d = s4_secfull[5:0];

    // stage 5
    s5_pc_d   = 53'(s4_cnum_q) * 53'(jdc_pkg::C_RECIP);
    s5_pmin_d = 19'(s4_min_q[10:2]) * 19'(jdc_pkg::MIN_RECIP);

    // stage 6: C, hour and minute
    s6_c_d     = s5_pc_q[52:jdc_pkg::C_K];
    s6_hour    = s5_pmin_q[17:jdc_pkg::MIN_K];
    s6_minfull = s5_min_q - 11'(s6_hour) * 11'd60;
    s6_tod_d.hour        = s6_hour;
    s6_tod_d.minute      = s6_minfull[5:0];
    s6_tod_d.second      = s5_second_q;
    s6_tod_d.millisecond = s5_ms_q;

    // stage 7: days into the March-based year
    s7_dprod  = 25'(s6_c_q) * jdc_pkg::D_SCALE;
    s7_bdfull = 23'(s6_b_q) - s7_dprod[24:2];
    s7_bd_d   = s7_bdfull[8:0];

    // stages 8 and 9: E numerator and reciprocal product
    s8_ne_d = 23'(s7_bd_q) * jdc_pkg::E_SCALE;
    s9_pe_d = 47'(s8_ne_q) * 47'(jdc_pkg::E_RECIP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_z_q      <= z_i;
      s1_greg_q   <= s1_greg_d;
      s1_anum_q   <= s1_anum_d;
      s1_msd_q    <= msd_i;
      s1_pms_q    <= s1_pms_d;

      s2_z_q      <= s1_z_q;
      s2_greg_q   <= s1_greg_q;
      s2_pa_q     <= s2_pa_d;
      s2_sec_q    <= s2_sec_d;
      s2_ms_q     <= s2_ms_d;

      s3_b_q      <= s3_b_d;
      s3_psec_q   <= s3_psec_d;
      s3_sec_q    <= s2_sec_q;
      s3_ms_q     <= s2_ms_q;

      s4_b_q      <= s3_b_q;
      s4_cnum_q   <= s4_cnum_d;
      s4_min_q    <= s4_min_d;
      s4_second_q <= s4_second_d;
      s4_ms_q     <= s3_ms_q;

      s5_b_q      <= s4_b_q;
      s5_pc_q     <= s5_pc_d;
      s5_pmin_q   <= s5_pmin_d;
      s5_min_q    <= s4_min_q;
      s5_second_q <= s4_second_q;
      s5_ms_q     <= s4_ms_q;

      s6_b_q      <= s5_b_q;
      s6_c_q      <= s6_c_d;
      s6_tod_q    <= s6_tod_d;

      s7_c_q      <= s6_c_q;
      s7_bd_q     <= s7_bd_d;
      s7_tod_q    <= s6_tod_q;

      s8_c_q      <= s7_c_q;
      s8_bd_q     <= s7_bd_q;
      s8_ne_q     <= s8_ne_d;
      s8_tod_q    <= s7_tod_q;

      s9_c_q      <= s8_c_q;
      s9_bd_q     <= s8_bd_q;
      s9_pe_q     <= s9_pe_d;
      s9_tod_q    <= s8_tod_q;
    end
  end

  // final step, registered by the output stage of the top level
  logic [3:0]  e_val;
  logic [8:0]  dom_full;
  logic [3:0]  mon;
  logic [14:0] yr_full;

  always_comb begin
    e_val    = s9_pe_q[45:jdc_pkg::E_K];
    dom_full = s9_bd_q - jdc_pkg::month_days(e_val);
    mon      = (e_val < jdc_pkg::MONTH_WRAP) ? (e_val - 4'd1) : (e_val - 4'd13);
    yr_full  = 15'(s9_c_q) -
               ((mon > jdc_pkg::FEBRUARY) ? jdc_pkg::YEAR_OFS_LATE : jdc_pkg::YEAR_OFS_EARLY);
  end

  assign valid_o = vld_q[NSTG-1];
  assign year_o  = yr_full[13:0];
  assign month_o = mon;
  assign day_o   = dom_full[4:0];
  assign tod_o   = s9_tod_q;

endmodule

`default_nettype wire

### rtl/core/julian_day_to_calendar_top.sv
// Julian date in milliseconds to calendar date and time of day, fully pipelined.
// Pipeline of 14 register stages: input, 3 divider stages by reciprocal product,
// 9 calendar stages, output.
// Throughput: one beat per cycle; all stages advance together whenever the output register
// is empty or being emptied, so a stall on the output holds the whole pipeline.
// Reset clears every valid bit; the data registers are not reset.
`default_nettype none

module julian_day_to_calendar_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [47:0]        julian_time_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [13:0] year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_o,
  output logic [4:0]         hour_o,
  output logic [5:0]         minute_o,
  output logic [5:0]         second_o,
  output logic [9:0]         millisecond_o
);

  logic          adv;
  logic          in_vld_q;
  logic [48:0]   t_q;
  logic [48:0]   t_d;

  logic          split_vld;
  logic [21:0]   split_z;
  logic [26:0]   split_msd;

  logic          cal_vld;
  logic [13:0]   cal_year;
  logic [3:0]    cal_month;
  logic [4:0]    cal_day;
  jdc_pkg::tod_t cal_tod;

  logic          out_vld_q;
  logic [13:0]   year_q;
  logic [3:0]    month_q;
  logic [4:0]    day_q;
  jdc_pkg::tod_t tod_q;

  // advance everything while the output slot is free or draining
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // shift to civil days, which start at midnight
  assign t_d = 49'(julian_time_ms_i) + jdc_pkg::MS_HALF_DAY;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q <= t_d;
    end
  end

  jdc_day_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_vld_q),
    .t_i     (t_q),
    .valid_o (split_vld),
    .z_o     (split_z),
    .msd_o   (split_msd)
  );

  jdc_calendar u_cal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (split_vld),
    .z_i     (split_z),
    .msd_i   (split_msd),
    .valid_o (cal_vld),
    .year_o  (cal_year),
    .month_o (cal_month),
    .day_o   (cal_day),
    .tod_o   (cal_tod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= cal_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && cal_vld) begin
      year_q  <= cal_year;
      month_q <= cal_month;
      day_q   <= cal_day;
      tod_q   <= cal_tod;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign year_o        = $signed(year_q);
  assign month_o       = month_q;
  assign day_o         = day_q;
  assign hour_o        = tod_q.hour;
  assign minute_o      = tod_q.minute;
  assign second_o      = tod_q.second;
  assign millisecond_o = tod_q.millisecond;

endmodule

`default_nettype wire
